FILE: hdl/swao_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swao_pkg
// Shared constants, types and command/status bundles of the sliding-window
// adaptive optimizer.
// ----------------------------------------------------------------------------
package swao_pkg;

    localparam int NUM_ELEMENTS = 1024;
    localparam int MAX_WINDOW   = 16;

    localparam int EW         = $clog2(NUM_ELEMENTS);
    localparam int SLW        = $clog2(MAX_WINDOW);
    localparam int FW         = $clog2(MAX_WINDOW + 1);
    localparam int RING_DEPTH = NUM_ELEMENTS * MAX_WINDOW;

    localparam int IDXW  = 10;
    localparam int DW    = 32;
    localparam int CFGW  = 17;
    localparam int WINW  = 5;
    localparam int CFGIW = 2;

    localparam int SUMW   = 36;
    localparam int ST_W   = 2 * SUMW + FW + SLW;
    localparam int RING_W = 2 * DW;
    localparam int FFW    = 20;
    localparam int PPW    = DW + FFW;
    localparam int SQW    = 24;
    localparam int DVW    = SQW + 1;
    localparam int DDW    = 49;
    localparam int NUMW   = 48;
    localparam int DCW    = $clog2(DDW + 1);
    localparam int SCW    = $clog2(SQW + 1);

    localparam int IN_TDATA_W  = 80;
    localparam int OUT_TDATA_W = 48;

    localparam logic [CFGW-1:0] LR_RST    = CFGW'(66);
    localparam logic [CFGW-1:0] EPS_RST   = CFGW'(1);
    localparam logic [CFGW-1:0] DECAY_RST = CFGW'(0);
    localparam logic [WINW-1:0] WIN_RST   = WINW'(16);

    typedef enum logic [CFGIW-1:0] {
        CFG_LR    = 2'd0,
        CFG_EPS   = 2'd1,
        CFG_DECAY = 2'd2,
        CFG_WIN   = 2'd3
    } t_cfg_idx;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_LOAD,
        S_RING,
        S_UPD,
        S_DECAY,
        S_DIVG_WAIT,
        S_DIVS_WAIT,
        S_SQRT_WAIT,
        S_MUL,
        S_CHK,
        S_DIVU_WAIT,
        S_FIN
    } t_state;

    typedef enum logic [1:0] {
        DIV_MEAN_G,
        DIV_MEAN_SQ,
        DIV_UPDATE
    } t_div_sel;

    typedef struct packed {
        logic signed [SUMW-1:0] gsum;
        logic [SUMW-1:0]        ssum;
        logic [FW-1:0]          fill;
        logic [SLW-1:0]         oldest;
    } t_elem;

    typedef struct packed {
        logic     clear;
        logic     load_in;
        logic     load_st;
        logic     evict;
        logic     update;
        logic     decay;
        logic     div_start;
        t_div_sel div_sel;
        logic     lat_mean;
        logic     sqrt_start;
        logic     mul;
        logic     fin;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic div_done;
        logic sqrt_done;
        logic d_zero;
        logic out_free;
    } t_sts;

endpackage

FILE: hdl/swao_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swao_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module swao_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: hdl/swao_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swao_ctrl
// Sequencer: clears the element state after reset, then walks one item at a
// time through load, window update, means, root and final division.
// ----------------------------------------------------------------------------
module swao_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output swao_pkg::t_cmd  o_cmd,
    input  swao_pkg::t_sts  i_sts
);
    import swao_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_cmd.div_sel = DIV_MEAN_G;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                o_cmd.load_st = 1'b1;
                n_state = S_RING;
            end
            S_RING: begin
                o_cmd.evict = 1'b1;
                n_state = S_UPD;
            end
            S_UPD: begin
                o_cmd.update = 1'b1;
                n_state = S_DECAY;
            end
            S_DECAY: begin
                o_cmd.decay     = 1'b1;
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DIV_MEAN_G;
                n_state = S_DIVG_WAIT;
            end
            S_DIVG_WAIT: begin
                if (i_sts.div_done) begin
                    o_cmd.lat_mean  = 1'b1;
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_sel   = DIV_MEAN_SQ;
                    n_state = S_DIVS_WAIT;
                end
            end
            S_DIVS_WAIT: begin
                if (i_sts.div_done) begin
                    o_cmd.sqrt_start = 1'b1;
                    n_state = S_SQRT_WAIT;
                end
            end
            S_SQRT_WAIT: begin
                if (i_sts.sqrt_done) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state = S_CHK;
            end
            S_CHK: begin
                if (i_sts.d_zero) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_sel   = DIV_UPDATE;
                    n_state = S_DIVU_WAIT;
                end
            end
            S_DIVU_WAIT: begin
                if (i_sts.div_done) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.fin = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

FILE: hdl/swao_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swao_dpath
// Datapath: configuration registers, element state and ring memories,
// decay and square multipliers, shared restoring divider, digit-serial root
// and the output register.
// ----------------------------------------------------------------------------
module swao_dpath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  swao_pkg::t_cmd                i_cmd,
    output swao_pkg::t_sts                o_sts,
    input  logic                          i_cfg_valid,
    input  logic [swao_pkg::CFGIW-1:0]    i_cfg_index,
    input  logic [swao_pkg::CFGW-1:0]     i_cfg_data,
    input  logic [swao_pkg::IDXW-1:0]     i_in_index,
    input  logic signed [swao_pkg::DW-1:0] i_in_value,
    input  logic signed [swao_pkg::DW-1:0] i_in_grad,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic [swao_pkg::IDXW-1:0]     o_out_index,
    output logic signed [swao_pkg::DW-1:0] o_out_value,
    output logic                          o_out_sat
);
    import swao_pkg::*;

    // configuration
    logic [CFGW-1:0] r_lr, r_eps, r_wd;
    logic [WINW-1:0] r_win_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lr      <= LR_RST;
            r_eps     <= EPS_RST;
            r_wd      <= DECAY_RST;
            r_win_cfg <= WIN_RST;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_LR:    r_lr      <= i_cfg_data;
                CFG_EPS:   r_eps     <= i_cfg_data;
                CFG_DECAY: r_wd      <= i_cfg_data;
                CFG_WIN:   r_win_cfg <= i_cfg_data[WINW-1:0];
            endcase
        end
    end

    // item registers
    logic [IDXW-1:0]        r_idx;
    logic signed [DW-1:0]   r_p, r_g;
    logic signed [SUMW-1:0] r_gsum;
    logic [SUMW-1:0]        r_ssum;
    logic [FW-1:0]          r_fill, r_win;
    logic [SLW-1:0]         r_oldest;
    logic [2*CFGW-1:0]      r_fprod;
    logic [2*DW-1:0]        r_sqprod;
    logic signed [FFW-1:0]  r_f;
    logic [DW-1:0]          r_sq;
    logic signed [PPW-1:0]  r_pprod;
    logic [DW-1:0]          r_mmag;
    logic [NUMW-1:0]        r_num;
    logic [DVW-1:0]         r_d;
    logic                   r_sat;
    logic [EW-1:0]          r_clr_addr;

    // memories
    t_elem             w_st_rd, w_st_wr, w_st_new;
    logic              w_st_we;
    logic [EW-1:0]     w_st_waddr;
    logic [RING_W-1:0] w_ring_rd;
    logic [SLW-1:0]    w_slot;

    assign w_slot   = r_oldest + r_fill[SLW-1:0];
    assign w_st_new = '{gsum:   r_gsum + SUMW'(r_g),
                        ssum:   r_ssum + SUMW'(r_sq),
                        fill:   r_fill + 1'b1,
                        oldest: r_oldest};
    assign w_st_we    = i_cmd.clear | i_cmd.update;
    assign w_st_waddr = i_cmd.clear ? r_clr_addr : r_idx[EW-1:0];
    assign w_st_wr    = i_cmd.clear ? '0 : w_st_new;

    swao_ram #(.WIDTH(ST_W), .DEPTH(NUM_ELEMENTS)) u_state_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_st_we),
        .i_wr_addr (w_st_waddr),
        .i_wr_data (w_st_wr),
        .i_rd_addr (i_in_index[EW-1:0]),
        .o_rd_data (w_st_rd)
    );

    swao_ram #(.WIDTH(RING_W), .DEPTH(RING_DEPTH)) u_ring_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.update),
        .i_wr_addr ({r_idx[EW-1:0], w_slot}),
        .i_wr_data ({r_sq, r_g}),
        .i_rd_addr ({r_idx[EW-1:0], w_st_rd.oldest}),
        .o_rd_data (w_ring_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clear) begin
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    // combinational helpers
    logic [DW-1:0]          w_gabs;
    logic [FW-1:0]          w_win;
    logic [2*CFGW:0]        w_frnd;
    logic [2*DW-1:0]        w_sqrnd;
    logic signed [PPW:0]    w_prnd, w_pshift;
    logic                   w_evict;
    logic [SUMW-1:0]        w_gsabs;

    assign w_gabs = r_g[DW-1] ? (~r_g + 1'b1) : r_g;
    assign w_frnd = {1'b0, r_fprod} + (2*CFGW+1)'(32768);
    assign w_sqrnd = (r_sqprod + (2*DW)'(32768)) >> 16;
    assign w_prnd  = {r_pprod[PPW-1], r_pprod} + (PPW+1)'(32768);
    assign w_pshift = w_prnd >>> 16;
    assign w_evict = (r_fill >= r_win);
    assign w_gsabs = r_gsum[SUMW-1] ? (~r_gsum + 1'b1) : r_gsum;

    always_comb begin
        w_win = FW'(r_win_cfg);
        if (r_win_cfg == '0) begin
            w_win = FW'(1);
        end else if (r_win_cfg > WINW'(MAX_WINDOW)) begin
            w_win = FW'(MAX_WINDOW);
        end
    end

    // shared restoring divider, one quotient bit per cycle
    logic [DDW-1:0] r_div_q, w_div_n;
    logic [DVW-1:0] r_div_rem, r_div_d, w_div_dv;
    logic [DCW-1:0] r_div_cnt;
    logic [DVW:0]   w_div_sh;

    always_comb begin
        w_div_n  = DDW'(r_num) + DDW'(r_d >> 1);
        w_div_dv = r_d;
        case (i_cmd.div_sel)
            DIV_MEAN_G: begin
                w_div_n  = DDW'(w_gsabs) + DDW'(r_fill >> 1);
                w_div_dv = DVW'(r_fill);
            end
            DIV_MEAN_SQ: begin
                w_div_n  = DDW'(r_ssum) + DDW'(r_fill >> 1);
                w_div_dv = DVW'(r_fill);
            end
            default: begin
                w_div_n  = DDW'(r_num) + DDW'(r_d >> 1);
                w_div_dv = r_d;
            end
        endcase
    end

    assign w_div_sh = {r_div_rem, r_div_q[DDW-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_cnt <= '0;
        end else if (i_cmd.div_start) begin
            r_div_cnt <= DCW'(DDW);
        end else if (r_div_cnt != '0) begin
            r_div_cnt <= r_div_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_div_q   <= w_div_n;
            r_div_rem <= '0;
            r_div_d   <= w_div_dv;
        end else if (r_div_cnt != '0) begin
            if (w_div_sh >= {1'b0, r_div_d}) begin
                r_div_rem <= DVW'(w_div_sh - {1'b0, r_div_d});
                r_div_q   <= {r_div_q[DDW-2:0], 1'b1};
            end else begin
                r_div_rem <= w_div_sh[DVW-1:0];
                r_div_q   <= {r_div_q[DDW-2:0], 1'b0};
            end
        end
    end

    // digit-serial integer square root, one root bit per cycle
    logic [2*SQW-1:0] r_sq_rad;
    logic [SQW-1:0]   r_sq_root;
    logic [SQW+1:0]   r_sq_rem;
    logic [SCW-1:0]   r_sq_cnt;
    logic [SQW+3:0]   w_sq_sh, w_sq_trial;

    assign w_sq_sh    = {r_sq_rem, r_sq_rad[2*SQW-1 -: 2]};
    assign w_sq_trial = (SQW+4)'({r_sq_root, 2'b01});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_cnt <= '0;
        end else if (i_cmd.sqrt_start) begin
            r_sq_cnt <= SCW'(SQW);
        end else if (r_sq_cnt != '0) begin
            r_sq_cnt <= r_sq_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.sqrt_start) begin
            r_sq_rad  <= {r_div_q[DW-1:0], 16'd0};
            r_sq_root <= '0;
            r_sq_rem  <= '0;
        end else if (r_sq_cnt != '0) begin
            r_sq_rad <= {r_sq_rad[2*SQW-3:0], 2'b00};
            if (w_sq_sh >= w_sq_trial) begin
                r_sq_rem  <= (SQW+2)'(w_sq_sh - w_sq_trial);
                r_sq_root <= {r_sq_root[SQW-2:0], 1'b1};
            end else begin
                r_sq_rem  <= w_sq_sh[SQW+1:0];
                r_sq_root <= {r_sq_root[SQW-2:0], 1'b0};
            end
        end
    end

    // item sequence
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_idx <= i_in_index;
            r_p   <= i_in_value;
            r_g   <= i_in_grad;
            r_sat <= 1'b0;
        end
        if (i_cmd.load_st) begin
            r_gsum   <= w_st_rd.gsum;
            r_ssum   <= w_st_rd.ssum;
            r_fill   <= w_st_rd.fill;
            r_oldest <= w_st_rd.oldest;
            r_win    <= w_win;
            r_fprod  <= r_lr * r_wd;
            r_sqprod <= w_gabs * w_gabs;
        end
        if (i_cmd.evict) begin
            r_f <= FFW'(65536) - $signed({1'b0, w_frnd[2*CFGW:16]});
            if (w_sqrnd[2*DW-1:DW] != '0) begin
                r_sq  <= '1;
                r_sat <= 1'b1;
            end else begin
                r_sq <= w_sqrnd[DW-1:0];
            end
            if (w_evict) begin
                r_gsum   <= r_gsum - SUMW'(signed'(w_ring_rd[DW-1:0]));
                r_ssum   <= r_ssum - SUMW'(w_ring_rd[RING_W-1:DW]);
                r_oldest <= r_oldest + 1'b1;
                r_fill   <= r_fill - 1'b1;
            end
        end
        if (i_cmd.update) begin
            r_gsum  <= w_st_new.gsum;
            r_ssum  <= w_st_new.ssum;
            r_fill  <= w_st_new.fill;
            r_pprod <= r_p * r_f;
        end
        if (i_cmd.decay && (r_wd != '0)) begin
            if (w_pshift > (PPW+1)'(2147483647)) begin
                r_p   <= 32'sh7FFF_FFFF;
                r_sat <= 1'b1;
            end else if (w_pshift < (PPW+1)'(-64'sd2147483648)) begin
                r_p   <= 32'sh8000_0000;
                r_sat <= 1'b1;
            end else begin
                r_p <= w_pshift[DW-1:0];
            end
        end
        if (i_cmd.lat_mean) begin
            r_mmag <= r_div_q[DW-1:0];
        end
        if (i_cmd.mul) begin
            r_num <= NUMW'(r_lr) * NUMW'(r_mmag);
            r_d   <= DVW'(r_sq_root) + DVW'(r_eps);
        end
    end

    // final update and output register
    logic signed [DDW+1:0] w_res;
    logic signed [DW-1:0]  w_fin;
    logic                  w_fin_sat;

    assign w_res = r_gsum[SUMW-1] ? ((DDW+2)'(r_p) + $signed({2'b00, r_div_q}))
                                  : ((DDW+2)'(r_p) - $signed({2'b00, r_div_q}));

    always_comb begin
        w_fin     = r_p;
        w_fin_sat = 1'b0;
        if (r_d == '0) begin
            if (r_num != '0) begin
                w_fin_sat = 1'b1;
                w_fin = r_gsum[SUMW-1] ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            end
        end else if (w_res > (DDW+2)'(2147483647)) begin
            w_fin = 32'sh7FFF_FFFF;
            w_fin_sat = 1'b1;
        end else if (w_res < (DDW+2)'(-64'sd2147483648)) begin
            w_fin = 32'sh8000_0000;
            w_fin_sat = 1'b1;
        end else begin
            w_fin = w_res[DW-1:0];
        end
    end

    logic r_o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.fin) begin
            r_o_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fin) begin
            o_out_index <= r_idx;
            o_out_value <= w_fin;
            o_out_sat   <= r_sat | w_fin_sat;
        end
    end

    assign o_out_valid = r_o_valid;

    assign o_sts.clr_last  = (r_clr_addr == EW'(NUM_ELEMENTS - 1));
    assign o_sts.div_done  = (r_div_cnt == '0);
    assign o_sts.sqrt_done = (r_sq_cnt == '0);
    assign o_sts.d_zero    = (r_d == '0);
    assign o_sts.out_free  = !r_o_valid || i_out_ready;

endmodule

FILE: hdl/sliding_window_adaptive_optimizer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_adaptive_optimizer_unit
// Per-element windowed gradient averaging with an adaptive step, Q16.16.
// ----------------------------------------------------------------------------
// One item is processed at a time. After load, window update and decay, the
// shared restoring divider forms the gradient mean and the squared-gradient
// mean, the square root of the latter follows, and a final division gives
// the step unless its divisor is zero. The result sits in an output register,
// so the next item is taken while it waits. After reset all 1024 entries of
// the element state memory are cleared, during which no item is taken;
// configuration writes are taken at any time but belong in idle periods.
module sliding_window_adaptive_optimizer_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // [9:0] element_index, [41:10] param_value, [73:42] gradient, rest zero
    input  logic [swao_pkg::IN_TDATA_W-1:0]    i_s_axis_tdata,
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // [9:0] out_index, [41:10] new_value, rest zero
    output logic [swao_pkg::OUT_TDATA_W-1:0]   o_m_axis_tdata,
    // [0] saturated
    output logic                               o_m_axis_tuser,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [swao_pkg::CFGIW-1:0]         i_cfg_index,
    input  logic [swao_pkg::CFGW-1:0]          i_cfg_data
);
    import swao_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    logic [IDXW-1:0]      w_out_index;
    logic signed [DW-1:0] w_out_value;

    swao_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .o_cmd      (w_cmd),
        .i_sts      (w_sts)
    );

    swao_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_index  (i_s_axis_tdata[IDXW-1:0]),
        .i_in_value  (i_s_axis_tdata[IDXW +: DW]),
        .i_in_grad   (i_s_axis_tdata[IDXW+DW +: DW]),
        .i_out_ready (i_m_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .o_out_index (w_out_index),
        .o_out_value (w_out_value),
        .o_out_sat   (o_m_axis_tuser)
    );

    assign o_m_axis_tdata = {(OUT_TDATA_W-IDXW-DW)'(0), w_out_value, w_out_index};
    assign o_cfg_ready    = 1'b1;

endmodule

FILE: hdl/swao_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swao_chk
// Port-level checks of the optimizer unit, bound to the top level.
// ----------------------------------------------------------------------------
module swao_chk (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_s_axis_tvalid,
    input logic                               o_s_axis_tready,
    input logic                               o_m_axis_tvalid,
    input logic                               i_m_axis_tready,
    input logic [swao_pkg::OUT_TDATA_W-1:0]   o_m_axis_tdata,
    input logic                               o_m_axis_tuser
);
    // reset starts the clearing pass with nothing in flight
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_s_axis_tready && !o_m_axis_tvalid)
        else $error("ready or valid high right after reset");

    // one item at a time
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("second item taken while one is in work");

    // a result never appears in the cycle right after its input transfer
    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready && !o_m_axis_tvalid) |=> !o_m_axis_tvalid)
        else $error("result appeared too early");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
            (o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser)))
        else $error("stalled result changed");

endmodule

bind sliding_window_adaptive_optimizer_unit swao_chk u_swao_chk (.*);
